### design/dmr_pkg.sv
// Package for the downmix linear resampler: widths, register indexes,
// reset values, shared types and the reciprocal table of the channel count.
// No dependencies; every other design file imports it.
package dmr_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_BITS  = 16;
    localparam int FRAC_BITS    = 16;
    localparam int CNT_W        = 4;
    localparam int STEP_W       = 20;
    localparam int POS_W        = 21;
    localparam int SUM_W        = SAMPLE_BITS + $clog2(MAX_CHANNELS);
    localparam int RECIP_BITS   = 24;
    localparam int RECIP_W      = RECIP_BITS + 1;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = STEP_W;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic [POS_W-1:0]              pos_t;
    typedef logic [STEP_W-1:0]             step_t;
    typedef logic [CNT_W-1:0]              count_t;
    typedef logic [CFG_IDX_W-1:0]          reg_index_t;
    typedef logic [CFG_DATA_W-1:0]         cfg_data_t;
    typedef logic [RECIP_W-1:0]            recip_t;

    // Register indexes of the configuration port.
    localparam reg_index_t REG_CHANNEL_COUNT = reg_index_t'(0);
    localparam reg_index_t REG_RATE_STEP     = reg_index_t'(1);

    localparam count_t CHANNEL_COUNT_RESET = count_t'(2);
    localparam step_t  RATE_STEP_RESET     = step_t'(196608);
    localparam count_t MAX_COUNT           = count_t'(MAX_CHANNELS);

    // One input period in position units, and the smallest allowed step.
    localparam pos_t  ONE_POS  = pos_t'(2 ** FRAC_BITS);
    localparam step_t MIN_STEP = step_t'(2 ** (FRAC_BITS - 2));

    // Effective configuration after clamping.
    typedef struct packed {
        count_t chans;
        step_t  step;
    } cfg_t;

    // Mono word from the merge stage to the interpolator.
    typedef struct packed {
        logic    valid;
        sample_t cur;
    } mono_word_t;

    // Q.24 reciprocal ceil(2^24/n) of the channel count.
    function automatic recip_t recip_of(count_t n);
        recip_t r;
        unique case (n)
            count_t'(1): r = recip_t'(16777216);
            count_t'(2): r = recip_t'(8388608);
            count_t'(3): r = recip_t'(5592406);
            count_t'(4): r = recip_t'(4194304);
            count_t'(5): r = recip_t'(3355444);
            count_t'(6): r = recip_t'(2796203);
            count_t'(7): r = recip_t'(2396746);
            count_t'(8): r = recip_t'(2097152);
            default:     r = '0;
        endcase
        return r;
    endfunction

endpackage

### design/dmr_frame_if.sv
// Input channel of the resampler: one multichannel frame per word.
// Depends on dmr_pkg for the sample type.
interface dmr_frame_if;
    import dmr_pkg::*;

    logic    valid;
    logic    ready;
    sample_t chan0_sample;
    sample_t chan1_sample;
    sample_t chan2_sample;
    sample_t chan3_sample;
    sample_t chan4_sample;
    sample_t chan5_sample;
    sample_t chan6_sample;
    sample_t chan7_sample;
    logic    final_frame;

    modport source (
        output valid, chan0_sample, chan1_sample, chan2_sample, chan3_sample,
               chan4_sample, chan5_sample, chan6_sample, chan7_sample, final_frame,
        input  ready
    );
    modport sink (
        input  valid, chan0_sample, chan1_sample, chan2_sample, chan3_sample,
               chan4_sample, chan5_sample, chan6_sample, chan7_sample, final_frame,
        output ready
    );
endinterface

### design/dmr_result_if.sv
// Output channel of the resampler: one mono sample per word with end flags.
// Depends on dmr_pkg for the sample type.
interface dmr_result_if;
    import dmr_pkg::*;

    logic    valid;
    logic    ready;
    sample_t mono_out;
    logic    run_end;
    logic    stream_end;

    modport source (
        output valid, mono_out, run_end, stream_end,
        input  ready
    );
    modport sink (
        input  valid, mono_out, run_end, stream_end,
        output ready
    );
endinterface

### design/dmr_cfg_if.sv
// Configuration write channel: register index and write data per word.
// Depends on dmr_pkg for the index and data types.
interface dmr_cfg_if;
    import dmr_pkg::*;

    logic       valid;
    logic       ready;
    reg_index_t reg_index;
    cfg_data_t  wr_data;

    modport source (
        output valid, reg_index, wr_data,
        input  ready
    );
    modport sink (
        input  valid, reg_index, wr_data,
        output ready
    );
endinterface

### design/downmix_linear_resampler_top.sv
// Downmix and linear resampler top level. One frame is in flight at a time and
// yields R results, R being 0 to 8. The lanes, the sum, the reciprocal multiply
// and the sign stage are registered in turn; then the interpolator emits one
// result per cycle through its single multiplier unless the output stalls.
// Reset clears stream state and loads channel_count = 2 and rate_step = 196608.
module downmix_linear_resampler_top (
    input  logic         clk,
    input  logic         rst_n,
    dmr_frame_if.sink    frame,
    dmr_result_if.source result,
    dmr_cfg_if.sink      cfg
);
    import dmr_pkg::*;

    count_t     channel_count_reg, channel_count_next;
    step_t      rate_step_reg, rate_step_next;
    logic       busy_reg, busy_next;
    logic       lane_valid_reg;
    logic       final_frame_reg;
    logic       accept;
    logic       done;
    cfg_t       cfg_eff;
    mono_word_t mono;
    sample_t    samples   [MAX_CHANNELS];
    sum_t       lane_vals [MAX_CHANNELS];

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        channel_count_next = channel_count_reg;
        rate_step_next     = rate_step_reg;
        if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                REG_CHANNEL_COUNT: channel_count_next = cfg.wr_data[CNT_W-1:0];
                REG_RATE_STEP:     rate_step_next     = cfg.wr_data[STEP_W-1:0];
                default:           ;
            endcase
        end
    end

    // Clamp the channel count to 1..8 and the step to at least a quarter.
    always_comb
    begin
        if (channel_count_reg == '0)
        begin
            cfg_eff.chans = count_t'(1);
        end
        else if (channel_count_reg > MAX_COUNT)
        begin
            cfg_eff.chans = MAX_COUNT;
        end
        else
        begin
            cfg_eff.chans = channel_count_reg;
        end
        cfg_eff.step = (rate_step_reg < MIN_STEP) ? MIN_STEP : rate_step_reg;
    end

    // One frame in flight at a time.
    assign frame.ready = !busy_reg;
    assign accept      = frame.valid && !busy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= CHANNEL_COUNT_RESET;
            rate_step_reg     <= RATE_STEP_RESET;
            busy_reg          <= 1'b0;
            lane_valid_reg    <= 1'b0;
        end
        else
        begin
            channel_count_reg <= channel_count_next;
            rate_step_reg     <= rate_step_next;
            busy_reg          <= busy_next;
            lane_valid_reg    <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            final_frame_reg <= frame.final_frame;
        end
    end

    // Channel lanes.
    assign samples[0] = frame.chan0_sample;
    assign samples[1] = frame.chan1_sample;
    assign samples[2] = frame.chan2_sample;
    assign samples[3] = frame.chan3_sample;
    assign samples[4] = frame.chan4_sample;
    assign samples[5] = frame.chan5_sample;
    assign samples[6] = frame.chan6_sample;
    assign samples[7] = frame.chan7_sample;

    for (genvar g = 0; g < MAX_CHANNELS; g++)
    begin : g_lane
        dmr_lane u_lane (
            .clk      (clk),
            .load     (accept),
            .enable   (count_t'(g) < cfg_eff.chans),
            .sample   (samples[g]),
            .lane_val (lane_vals[g])
        );
    end

    // Lane merge into one mono word.
    dmr_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_valid (lane_valid_reg),
        .lane_vals  (lane_vals),
        .cfg        (cfg_eff),
        .mono       (mono)
    );

    // Interpolation and output.
    dmr_interp u_interp (
        .clk         (clk),
        .rst_n       (rst_n),
        .mono        (mono),
        .final_frame (final_frame_reg),
        .cfg         (cfg_eff),
        .done        (done),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .mono_out    (result.mono_out),
        .run_end     (result.run_end),
        .stream_end  (result.stream_end)
    );
endmodule

### design/dmr_lane.sv
// One channel lane: gates a sample by the active channel count and
// sign-extends it to the width of the channel sum. Depends on dmr_pkg.
module dmr_lane (
    input  logic             clk,
    input  logic             load,
    input  logic             enable,
    input  dmr_pkg::sample_t sample,
    output dmr_pkg::sum_t    lane_val
);
    import dmr_pkg::*;

    sum_t lane_val_reg;
    sum_t lane_val_next;

    // Inactive channels contribute zero to the sum.
    always_comb
    begin
        lane_val_next = lane_val_reg;
        if (load)
        begin
            lane_val_next = enable ? sum_t'(sample) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_val_reg <= lane_val_next;
    end

    assign lane_val = lane_val_reg;
endmodule

### design/dmr_merge.sv
// Merge stage: adds the lane values and scales the sum by the tabulated
// reciprocal of the channel count, truncating toward zero. Depends on dmr_pkg.
module dmr_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                lane_valid,
    input  dmr_pkg::sum_t       lane_vals [dmr_pkg::MAX_CHANNELS],
    input  dmr_pkg::cfg_t       cfg,
    output dmr_pkg::mono_word_t mono
);
    import dmr_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_W;

    logic                  sum_valid_reg;
    logic                  prod_valid_reg;
    logic                  cur_valid_reg;
    sum_t                  sum_reg;
    sum_t                  sum_next;
    logic                  neg_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [PROD_W-1:0]     prod_next;
    logic [SUM_W-1:0]      mag;
    logic [SAMPLE_BITS-1:0] quot;
    sample_t               cur_reg;
    sample_t               cur_next;

    // Channel sum over all lanes; inactive lanes hold zero.
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            sum_next = sum_next + lane_vals[i];
        end
    end

    // Magnitude times the Q.24 reciprocal.
    always_comb
    begin
        mag       = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        prod_next = PROD_W'(mag) * PROD_W'(recip_of(cfg.chans));
    end

    // Drop the fraction and restore the sign.
    always_comb
    begin
        quot     = prod_reg[RECIP_BITS+SAMPLE_BITS-1:RECIP_BITS];
        cur_next = neg_reg ? sample_t'(-quot) : sample_t'(quot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            cur_valid_reg  <= 1'b0;
        end
        else
        begin
            sum_valid_reg  <= lane_valid;
            prod_valid_reg <= sum_valid_reg;
            cur_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        neg_reg  <= sum_reg[SUM_W-1];
        prod_reg <= prod_next;
        cur_reg  <= cur_next;
    end

    assign mono.valid = cur_valid_reg;
    assign mono.cur   = cur_reg;
endmodule

### design/dmr_interp.sv
// Interpolation sequencer: walks the output positions between the previous
// and the current mono sample, then the tail copies on the final frame.
// One multiplier stage and one output register. Depends on dmr_pkg.
module dmr_interp (
    input  logic                clk,
    input  logic                rst_n,
    input  dmr_pkg::mono_word_t mono,
    input  logic                final_frame,
    input  dmr_pkg::cfg_t       cfg,
    output logic                done,
    output logic                out_valid,
    input  logic                out_ready,
    output dmr_pkg::sample_t    mono_out,
    output logic                run_end,
    output logic                stream_end
);
    import dmr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INTERP,
        ST_TAIL
    } state_t;

    state_t  state_reg, state_next;
    sample_t prev_reg, prev_next;
    logic    have_prev_reg, have_prev_next;
    pos_t    pos_reg, pos_next;
    sample_t cur_reg, cur_next;

    logic    s1_valid_reg, s1_valid_next;
    sample_t s1_base_reg, s1_base_next;
    sample_t s1_delta_reg, s1_delta_next;
    logic    s1_run_end_reg, s1_run_end_next;
    logic    s1_stream_end_reg, s1_stream_end_next;

    logic    out_valid_reg, out_valid_next;
    sample_t out_mono_reg, out_mono_next;
    logic    out_run_end_reg, out_run_end_next;
    logic    out_stream_end_reg, out_stream_end_next;

    logic    out_free;
    logic    issue_ok;
    logic    s1_move;
    logic    issue;
    logic    issue_tail;
    logic    issue_last;
    logic    issue_stream;
    pos_t    step_pos;
    pos_t    next_pos;
    pos_t    wrap_pos;
    pos_t    start_pos;

    logic signed [SAMPLE_BITS:0]             diff_w;
    logic signed [FRAC_BITS:0]               frac_w;
    logic signed [SAMPLE_BITS+FRAC_BITS+1:0] prod_w;

    // Handshake between the multiplier stage and the output register.
    assign out_free = !out_valid_reg || out_ready;
    assign issue_ok = !s1_valid_reg || out_free;
    assign s1_move  = s1_valid_reg && out_free;

    // Position arithmetic for the next output.
    always_comb
    begin
        step_pos  = pos_t'(cfg.step);
        next_pos  = pos_reg + step_pos;
        wrap_pos  = next_pos - ONE_POS;
        start_pos = have_prev_reg ? (pos_reg - ONE_POS) : pos_reg;
    end

    // Interpolation product (cur - prev) * frac, floor-shifted.
    always_comb
    begin
        diff_w = $signed({cur_reg[SAMPLE_BITS-1], cur_reg})
               - $signed({prev_reg[SAMPLE_BITS-1], prev_reg});
        frac_w = $signed({1'b0, pos_reg[FRAC_BITS-1:0]});
        prod_w = diff_w * frac_w;
    end

    // Sequencer: decides which positions produce a word and what follows.
    always_comb
    begin
        state_next     = state_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        done           = 1'b0;
        issue          = 1'b0;
        issue_tail     = 1'b0;
        issue_last     = 1'b0;
        issue_stream   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (mono.valid)
                begin
                    cur_next = mono.cur;
                    if (have_prev_reg && (pos_reg < ONE_POS))
                    begin
                        state_next = ST_INTERP;
                    end
                    else if (final_frame && (start_pos < ONE_POS))
                    begin
                        pos_next   = start_pos;
                        state_next = ST_TAIL;
                    end
                    else if (final_frame)
                    begin
                        prev_next      = '0;
                        have_prev_next = 1'b0;
                        pos_next       = '0;
                        done           = 1'b1;
                    end
                    else
                    begin
                        prev_next      = mono.cur;
                        have_prev_next = 1'b1;
                        pos_next       = start_pos;
                        done           = 1'b1;
                    end
                end
            end
            ST_INTERP:
            begin
                if (issue_ok)
                begin
                    issue = 1'b1;
                    if (next_pos < ONE_POS)
                    begin
                        pos_next = next_pos;
                    end
                    else if (final_frame && (wrap_pos < ONE_POS))
                    begin
                        pos_next   = wrap_pos;
                        state_next = ST_TAIL;
                    end
                    else if (final_frame)
                    begin
                        issue_last     = 1'b1;
                        issue_stream   = 1'b1;
                        prev_next      = '0;
                        have_prev_next = 1'b0;
                        pos_next       = '0;
                        done           = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        issue_last     = 1'b1;
                        prev_next      = cur_reg;
                        have_prev_next = 1'b1;
                        pos_next       = wrap_pos;
                        done           = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_TAIL:
            begin
                if (issue_ok)
                begin
                    issue      = 1'b1;
                    issue_tail = 1'b1;
                    if (next_pos < ONE_POS)
                    begin
                        pos_next = next_pos;
                    end
                    else
                    begin
                        issue_last     = 1'b1;
                        issue_stream   = 1'b1;
                        prev_next      = '0;
                        have_prev_next = 1'b0;
                        pos_next       = '0;
                        done           = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Multiplier stage: tail copies use a zero delta.
    always_comb
    begin
        s1_valid_next      = s1_valid_reg;
        s1_base_next       = s1_base_reg;
        s1_delta_next      = s1_delta_reg;
        s1_run_end_next    = s1_run_end_reg;
        s1_stream_end_next = s1_stream_end_reg;
        if (issue)
        begin
            s1_valid_next      = 1'b1;
            s1_base_next       = issue_tail ? cur_reg : prev_reg;
            s1_delta_next      = issue_tail ? '0
                               : sample_t'(prod_w[SAMPLE_BITS+FRAC_BITS-1:FRAC_BITS]);
            s1_run_end_next    = issue_last;
            s1_stream_end_next = issue_stream;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next      = out_valid_reg;
        out_mono_next       = out_mono_reg;
        out_run_end_next    = out_run_end_reg;
        out_stream_end_next = out_stream_end_reg;
        if (s1_move)
        begin
            out_valid_next      = 1'b1;
            out_mono_next       = s1_base_reg + s1_delta_reg;
            out_run_end_next    = s1_run_end_reg;
            out_stream_end_next = s1_stream_end_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            prev_reg           <= '0;
            have_prev_reg      <= 1'b0;
            pos_reg            <= '0;
            cur_reg            <= '0;
            s1_valid_reg       <= 1'b0;
            s1_base_reg        <= '0;
            s1_delta_reg       <= '0;
            s1_run_end_reg     <= 1'b0;
            s1_stream_end_reg  <= 1'b0;
            out_valid_reg      <= 1'b0;
            out_mono_reg       <= '0;
            out_run_end_reg    <= 1'b0;
            out_stream_end_reg <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            prev_reg           <= prev_next;
            have_prev_reg      <= have_prev_next;
            pos_reg            <= pos_next;
            cur_reg            <= cur_next;
            s1_valid_reg       <= s1_valid_next;
            s1_base_reg        <= s1_base_next;
            s1_delta_reg       <= s1_delta_next;
            s1_run_end_reg     <= s1_run_end_next;
            s1_stream_end_reg  <= s1_stream_end_next;
            out_valid_reg      <= out_valid_next;
            out_mono_reg       <= out_mono_next;
            out_run_end_reg    <= out_run_end_next;
            out_stream_end_reg <= out_stream_end_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign mono_out   = out_mono_reg;
    assign run_end    = out_run_end_reg;
    assign stream_end = out_stream_end_reg;
endmodule
